// ===== rtl/cpg_pkg.sv =====
`timescale 1ns / 1ps

package cpg_pkg;

    // Input item kind, carried on the slave-side tuser
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // Configuration register indexes
    localparam int unsigned REG_PEN_COLOUR = 0;
    localparam int unsigned NUM_REGS       = 1;

    localparam int unsigned COLOUR_W   = 16;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 3;

    // Pixel beats per drawing step
    localparam int unsigned BEATS_PER_STEP = 8;
    localparam int unsigned BEAT_W         = 3;
    localparam logic [BEAT_W-1:0] BEAT_LAST = 3'd7;

    // Which offset each coordinate takes and whether it is subtracted
    typedef struct packed {
        logic x_use_b;
        logic x_neg;
        logic y_use_b;
        logic y_neg;
    } t_octant;

    // Octant order: (+a,-b) (+b,-a) (+b,+a) (+a,+b) (-a,+b) (-b,+a) (-a,-b) (-b,-a)
    function automatic t_octant octant_sel(input logic [BEAT_W-1:0] beat);
        t_octant sel;
        sel = '0;
        case (beat)
            3'd0: sel = '{x_use_b: 1'b0, x_neg: 1'b0, y_use_b: 1'b1, y_neg: 1'b1};
            3'd1: sel = '{x_use_b: 1'b1, x_neg: 1'b0, y_use_b: 1'b0, y_neg: 1'b1};
            3'd2: sel = '{x_use_b: 1'b1, x_neg: 1'b0, y_use_b: 1'b0, y_neg: 1'b0};
            3'd3: sel = '{x_use_b: 1'b0, x_neg: 1'b0, y_use_b: 1'b1, y_neg: 1'b0};
            3'd4: sel = '{x_use_b: 1'b0, x_neg: 1'b1, y_use_b: 1'b1, y_neg: 1'b0};
            3'd5: sel = '{x_use_b: 1'b1, x_neg: 1'b1, y_use_b: 1'b0, y_neg: 1'b0};
            3'd6: sel = '{x_use_b: 1'b0, x_neg: 1'b1, y_use_b: 1'b1, y_neg: 1'b1};
            3'd7: sel = '{x_use_b: 1'b1, x_neg: 1'b1, y_use_b: 1'b0, y_neg: 1'b1};
            default: sel = '0;
        endcase
        return sel;
    endfunction

endpackage

// ===== rtl/circle_pixel_generator_core.sv =====
`timescale 1ns / 1ps

// Midpoint circle rasterizer with eight-way symmetry.
// Slave stream: s_axis_tuser selects the request kind. A start request loads
// centre and radius and produces nothing. A step request, while the current
// circle still has octant points left, produces eight pixel writes on the
// master stream; a step after the circle is finished produces nothing.
// Master stream: tdata holds column, row and pen colour; tlast marks the
// eighth pixel of a step; tuser flags that this step finished the circle.
// The first pixel of a step is valid in the cycle after the step request
// is accepted. Output runs at one pixel per cycle while the receiver
// accepts; start requests and idle steps produce no output. The next request
// is taken in the same cycle as the eighth pixel leaves, so back-to-back steps
// keep the output busy. When the receiver stalls, the current pixel holds and
// no new request is taken until the last pixel of the step is accepted.
// Reset (synchronous, active low) clears the pen colour and the centre and
// leaves the rasterizer finished (a=1, b=0), so steps do nothing until a
// start request arrives. The pen colour is written through the APB port at
// address 0 and is sampled when a step request is accepted.
module circle_pixel_generator_core #(
    parameter int unsigned COORD_BITS  = 16,
    parameter int unsigned RADIUS_BITS = 8,
    // derived widths of the stream data buses, rounded up to whole bytes
    localparam int unsigned IN_DATA_W  = ((2 * COORD_BITS + RADIUS_BITS + 7) / 8) * 8,
    localparam int unsigned OUT_DATA_W = ((2 * COORD_BITS + 16 + 7) / 8) * 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: centre_x, centre_y, radius (from bit 0 up), zero padded
    input  logic [IN_DATA_W-1:0]              s_axis_tdata,
    // tuser: cmd
    input  logic                              s_axis_tuser,
    // master stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: pixel_x, pixel_y, pixel_colour (from bit 0 up), zero padded
    output logic [OUT_DATA_W-1:0]             m_axis_tdata,
    // tlast: last_of_step
    output logic                              m_axis_tlast,
    // tuser: circle_done
    output logic                              m_axis_tuser,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cpg_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [cpg_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [cpg_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import cpg_pkg::*;

    localparam int unsigned OFF_W = RADIUS_BITS + 1;
    localparam int unsigned DEC_W = RADIUS_BITS + 4;
    localparam int unsigned SUM_W = COORD_BITS + RADIUS_BITS + 1;

    // circle state
    logic [COORD_BITS-1:0] r_cx, r_cy;
    logic [OFF_W-1:0]      r_a, r_b;
    logic [DEC_W-1:0]      r_dec;
    logic [COLOUR_W-1:0]   r_pen;

    // snapshot of the step being emitted
    logic                  r_busy;
    logic [BEAT_W-1:0]     r_beat;
    logic [COORD_BITS-1:0] r_snap_cx, r_snap_cy;
    logic [OFF_W-1:0]      r_snap_a, r_snap_b;
    logic [COLOUR_W-1:0]   r_snap_colour;
    logic                  r_snap_done;

    logic                  w_in_acc, w_out_take, w_draw, w_cfg_wr;
    logic [COORD_BITS-1:0] w_in_cx, w_in_cy;
    logic [RADIUS_BITS-1:0] w_in_r;
    logic [OFF_W-1:0]      n_a, n_b;
    logic [DEC_W-1:0]      n_dec, w_na4, w_b4;

    // Accept a new request when nothing is pending or the last pixel leaves now
    assign s_axis_tready = !r_busy || ((r_beat == BEAT_LAST) && m_axis_tready);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_take    = r_busy && m_axis_tready;
    assign w_draw        = w_in_acc && (s_axis_tuser == CMD_STEP) && !(r_a > r_b);

    assign w_in_cx = s_axis_tdata[COORD_BITS-1:0];
    assign w_in_cy = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign w_in_r  = s_axis_tdata[2*COORD_BITS+RADIUS_BITS-1:2*COORD_BITS];

    // Advance a, b and the decision value for one step
    assign n_a   = r_a + OFF_W'(1);
    assign w_na4 = DEC_W'(n_a) << 2;
    assign w_b4  = DEC_W'(r_b) << 2;

    always_comb begin
        if (r_dec[DEC_W-1]) begin
            n_dec = r_dec + w_na4 + DEC_W'(6);
            n_b   = r_b;
        end else begin
            n_dec = r_dec + DEC_W'(10) + w_na4 - w_b4;
            n_b   = (r_b != '0) ? (r_b - OFF_W'(1)) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx  <= '0;
            r_cy  <= '0;
            r_a   <= OFF_W'(1);
            r_b   <= '0;
            r_dec <= '0;
        end else if (w_in_acc && (s_axis_tuser == CMD_START)) begin
            r_cx  <= w_in_cx;
            r_cy  <= w_in_cy;
            r_a   <= '0;
            r_b   <= OFF_W'(w_in_r);
            r_dec <= DEC_W'(3) - (DEC_W'(w_in_r) << 1);
        end else if (w_draw) begin
            r_a   <= n_a;
            r_b   <= n_b;
            r_dec <= n_dec;
        end
    end

    // Output sequencer: one pixel per beat from the snapshot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_beat <= '0;
        end else if (w_draw) begin
            r_busy <= 1'b1;
            r_beat <= '0;
        end else if (w_out_take) begin
            if (r_beat == BEAT_LAST) begin
                r_busy <= 1'b0;
            end
            r_beat <= r_beat + BEAT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_draw) begin
            r_snap_cx     <= r_cx;
            r_snap_cy     <= r_cy;
            r_snap_a      <= r_a;
            r_snap_b      <= r_b;
            r_snap_colour <= r_pen;
            r_snap_done   <= n_a > n_b;
        end
    end

    // Pixel coordinates for the current octant, wrapped to COORD_BITS
    t_octant               w_oct;
    logic [OFF_W-1:0]      w_off_x, w_off_y;
    logic [SUM_W-1:0]      w_sum_x, w_sum_y;
    logic [COORD_BITS-1:0] w_px, w_py;

    assign w_oct   = octant_sel(r_beat);
    assign w_off_x = w_oct.x_use_b ? r_snap_b : r_snap_a;
    assign w_off_y = w_oct.y_use_b ? r_snap_b : r_snap_a;
    assign w_sum_x = w_oct.x_neg ? (SUM_W'(r_snap_cx) - SUM_W'(w_off_x))
                                 : (SUM_W'(r_snap_cx) + SUM_W'(w_off_x));
    assign w_sum_y = w_oct.y_neg ? (SUM_W'(r_snap_cy) - SUM_W'(w_off_y))
                                 : (SUM_W'(r_snap_cy) + SUM_W'(w_off_y));
    assign w_px    = w_sum_x[COORD_BITS-1:0];
    assign w_py    = w_sum_y[COORD_BITS-1:0];

    assign m_axis_tvalid = r_busy;
    assign m_axis_tdata  = OUT_DATA_W'({r_snap_colour, w_py, w_px});
    assign m_axis_tlast  = (r_beat == BEAT_LAST);
    assign m_axis_tuser  = r_snap_done && (r_beat == BEAT_LAST);

    // Configuration: pen colour at word 0
    logic w_addr_pen;

    assign pready     = 1'b1;
    assign w_addr_pen = (paddr[APB_ADDR_W-1:2] == 1'(REG_PEN_COLOUR));
    assign w_cfg_wr   = psel && penable && pwrite && pready && w_addr_pen;
    assign prdata     = w_addr_pen ? APB_DATA_W'(r_pen) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen <= '0;
        end else if (w_cfg_wr) begin
            r_pen <= pwdata[COLOUR_W-1:0];
        end
    end

    // A drawing step starts its first pixel on the next cycle
    a_draw_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_draw |=> (m_axis_tvalid && (r_beat == '0)))
        else $error("drawing step did not start at its first pixel");

    // Output goes quiet after the last pixel unless a new step was drawn
    a_step_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast && !w_draw) |=> !m_axis_tvalid)
        else $error("pixel output kept running after the last pixel");

    // Only steps with a not past b are ever emitted
    a_snap_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_snap_a <= r_snap_b))
        else $error("emitting a step past the end of the circle");

endmodule
